>>> sv/hibf_pkg.sv
// Package for the hash index build and find unit.
// Holds field widths, opcode and status codes and reset defaults.
// No dependencies; every other file of the block uses it.
package hibf_pkg;

    localparam int TABLE_SLOTS_DEFAULT = 1024;
    localparam int KEY_BITS_DEFAULT    = 64;

    localparam int OPCODE_W = 2;
    localparam int HOME_W   = 10;
    localparam int KEY_W    = 64;
    localparam int STATUS_W = 2;
    localparam int ROW_W    = 10;
    localparam int COUNT_W  = 11;
    localparam int CFG_W    = 11;

    localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 11'd1024;

    localparam logic [OPCODE_W-1:0] OP_LOAD     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FINALIZE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd3;

endpackage

>>> sv/hibf_req_if.sv
// Request channel of the hash index unit: opcode, home slot and key.
// Depends on hibf_pkg for the field widths.
interface hibf_req_if;
    logic                          valid;
    logic                          ready;
    logic [hibf_pkg::OPCODE_W-1:0] opcode;
    logic [hibf_pkg::HOME_W-1:0]   home_slot;
    logic [hibf_pkg::KEY_W-1:0]    key_value;

    modport source (output valid, opcode, home_slot, key_value, input ready);
    modport sink   (input valid, opcode, home_slot, key_value, output ready);
endinterface

>>> sv/hibf_rsp_if.sv
// Response channel of the hash index unit: status, row, count and conflicts.
// Depends on hibf_pkg for the field widths.
interface hibf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [hibf_pkg::STATUS_W-1:0] status;
    logic [hibf_pkg::ROW_W-1:0]    row_index;
    logic [hibf_pkg::COUNT_W-1:0]  match_count;
    logic [hibf_pkg::COUNT_W-1:0]  conflict_total;

    modport source (output valid, status, row_index, match_count, conflict_total,
                    input ready);
    modport sink   (input valid, status, row_index, match_count, conflict_total,
                    output ready);
endinterface

>>> sv/hibf_cfg_if.sv
// Configuration write channel of the hash index unit (slots_in_use).
// Depends on hibf_pkg for the register width.
interface hibf_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [hibf_pkg::CFG_W-1:0] slots_in_use;

    modport source (output valid, slots_in_use, input ready);
    modport sink   (input valid, slots_in_use, output ready);
endinterface

>>> sv/hash_index_build_and_find_unit.sv
// Top level of the hash index build and find unit (coalesced hashing).
// Depends on hibf_pkg and the interfaces hibf_req_if, hibf_rsp_if, hibf_cfg_if.
//
//  channel  role    payload
//  req      sink    opcode, home_slot, key_value
//  rsp      source  status, row_index, match_count, conflict_total
//  cfg      sink    slots_in_use (always ready)
//
// Requests are taken only in the idle state. A load reads the home slot, then
// updates that slot or the spill stack, unless the spill stack is full.
// A lookup reads the home slot, then follows the chain one entry at a time; a
// rejected request goes straight to its result. Finalize scans the slots and
// fills each free one with the top spill entry, then walks that entry's home
// chain to the tail and links it in. After reset and after a clear, a pass writes
// every slot while no request is taken. A waiting result does not block the next
// request; that request's result is held until the output register is free.
module hash_index_build_and_find_unit #(
    parameter int TABLE_SLOTS = hibf_pkg::TABLE_SLOTS_DEFAULT,
    parameter int KEY_BITS    = hibf_pkg::KEY_BITS_DEFAULT
) (
    input logic        clk,
    input logic        rst_n,
    hibf_req_if.sink   req,
    hibf_rsp_if.source rsp,
    hibf_cfg_if.sink   cfg
);

    localparam int AW      = $clog2(TABLE_SLOTS);
    localparam int CW      = $clog2(TABLE_SLOTS + 1);
    localparam int ROW_W   = hibf_pkg::ROW_W;
    localparam int COUNT_W = hibf_pkg::COUNT_W;
    localparam logic [CW-1:0] NO_LINK  = CW'(TABLE_SLOTS);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SLOTS - 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LD    = 4'd2;
    localparam logic [3:0] S_FRD   = 4'd3;
    localparam logic [3:0] S_FCHK  = 4'd4;
    localparam logic [3:0] S_FWALK = 4'd5;
    localparam logic [3:0] S_LK    = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    typedef struct packed {
        logic                used;
        logic [CW-1:0]       nxt;
        logic [CW-1:0]       dup;
        logic [AW-1:0]       row;
        logic [KEY_BITS-1:0] key;
    } slot_t;

    typedef struct packed {
        logic [AW-1:0]       row;
        logic [KEY_BITS-1:0] key;
        logic [AW-1:0]       home;
        logic [CW-1:0]       dup;
    } spill_t;

    slot_t  slot_mem [TABLE_SLOTS];
    spill_t spill_mem [TABLE_SLOTS];

    logic          slot_we, slot_re, spill_we, spill_re;
    logic [AW-1:0] slot_wa, slot_ra, spill_wa, spill_ra;
    slot_t         slot_wd, slot_q;
    spill_t        spill_wd, spill_q;

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (slot_re)
        begin
            slot_q <= slot_mem[slot_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (spill_we)
        begin
            spill_mem[spill_wa] <= spill_wd;
        end
        if (spill_re)
        begin
            spill_q <= spill_mem[spill_ra];
        end
    end

    logic [3:0]          state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                clr_rsp_reg, clr_rsp_next;
    logic [AW-1:0]       home_reg, home_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic [CW-1:0]       top_reg, top_next;
    logic [CW-1:0]       rows_reg, rows_next;
    logic                ready_reg, ready_next;
    logic [CW-1:0]       total_reg, total_next;
    spill_t              ctop_reg, ctop_next;
    logic [hibf_pkg::CFG_W-1:0] slots_reg;

    logic [hibf_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [CW-1:0]                 res_row_reg, res_row_next;
    logic [CW-1:0]                 res_cnt_reg, res_cnt_next;
    logic [CW-1:0]                 res_conf_reg, res_conf_next;

    logic                          out_valid_reg, out_valid_next;
    logic [hibf_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [ROW_W-1:0]              out_row_reg, out_row_next;
    logic [COUNT_W-1:0]            out_cnt_reg, out_cnt_next;
    logic [COUNT_W-1:0]            out_conf_reg, out_conf_next;

    logic [CW-1:0]       lim;
    logic                req_fire, home_bad;
    logic [KEY_BITS-1:0] req_key;

    always_comb
    begin
        if (slots_reg == '0)
        begin
            lim = CW'(1);
        end
        else if (32'(slots_reg) > TABLE_SLOTS)
        begin
            lim = NO_LINK;
        end
        else
        begin
            lim = CW'(slots_reg);
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign req_key   = KEY_BITS'(req.key_value);
    assign home_bad  = 32'(req.home_slot) >= 32'(lim);
    assign cfg.ready = 1'b1;

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.row_index      = out_row_reg;
    assign rsp.match_count    = out_cnt_reg;
    assign rsp.conflict_total = out_conf_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        clr_rsp_next    = clr_rsp_reg;
        home_next       = home_reg;
        key_next        = key_reg;
        cur_next        = cur_reg;
        scan_next       = scan_reg;
        top_next        = top_reg;
        rows_next       = rows_reg;
        ready_next      = ready_reg;
        total_next      = total_reg;
        ctop_next       = ctop_reg;
        res_status_next = res_status_reg;
        res_row_next    = res_row_reg;
        res_cnt_next    = res_cnt_reg;
        res_conf_next   = res_conf_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_row_next    = out_row_reg;
        out_cnt_next    = out_cnt_reg;
        out_conf_next   = out_conf_reg;
        slot_we  = 1'b0;
        slot_re  = 1'b0;
        slot_wa  = '0;
        slot_ra  = '0;
        slot_wd  = slot_q;
        spill_we = 1'b0;
        spill_re = 1'b0;
        spill_wa = '0;
        spill_ra = '0;
        spill_wd = ctop_reg;

        case (state_reg)
            S_CLR:
            begin
                slot_we     = 1'b1;
                slot_wa     = clr_reg;
                slot_wd     = '0;
                slot_wd.nxt = NO_LINK;
                clr_next    = clr_reg + AW'(1);
                if (clr_reg == LAST_IDX)
                begin
                    clr_next = '0;
                    if (clr_rsp_reg)
                    begin
                        res_status_next = hibf_pkg::ST_OK;
                        res_row_next    = '0;
                        res_cnt_next    = '0;
                        res_conf_next   = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    home_next       = AW'(req.home_slot);
                    key_next        = req_key;
                    cur_next        = AW'(req.home_slot);
                    res_status_next = hibf_pkg::ST_OK;
                    res_row_next    = '0;
                    res_cnt_next    = '0;
                    res_conf_next   = '0;
                    case (req.opcode)
                        hibf_pkg::OP_LOAD:
                        begin
                            if (ready_reg || home_bad || rows_reg >= lim)
                            begin
                                res_status_next = hibf_pkg::ST_OVERFLOW;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                slot_re    = 1'b1;
                                slot_ra    = AW'(req.home_slot);
                                state_next = S_LD;
                            end
                        end
                        hibf_pkg::OP_FINALIZE:
                        begin
                            total_next = top_reg;
                            scan_next  = '0;
                            state_next = S_FRD;
                        end
                        hibf_pkg::OP_LOOKUP:
                        begin
                            if (!ready_reg)
                            begin
                                res_status_next = hibf_pkg::ST_NOT_READY;
                                state_next      = S_DONE;
                            end
                            else if (home_bad)
                            begin
                                res_status_next = hibf_pkg::ST_NOT_FOUND;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                slot_re    = 1'b1;
                                slot_ra    = AW'(req.home_slot);
                                state_next = S_LK;
                            end
                        end
                        default:
                        begin
                            top_next     = '0;
                            rows_next    = '0;
                            ready_next   = 1'b0;
                            clr_next     = '0;
                            clr_rsp_next = 1'b1;
                            state_next   = S_CLR;
                        end
                    endcase
                end
            end

            S_LD:
            begin
                state_next = S_DONE;
                if (!slot_q.used)
                begin
                    slot_we      = 1'b1;
                    slot_wa      = home_reg;
                    slot_wd.used = 1'b1;
                    slot_wd.row  = AW'(rows_reg);
                    slot_wd.key  = key_reg;
                    slot_wd.dup  = CW'(1);
                    rows_next    = rows_reg + CW'(1);
                    res_row_next = rows_reg;
                    res_cnt_next = CW'(1);
                end
                else if (slot_q.key == key_reg)
                begin
                    slot_we      = 1'b1;
                    slot_wa      = home_reg;
                    slot_wd.dup  = slot_q.dup + CW'(1);
                    rows_next    = rows_reg + CW'(1);
                    res_row_next = CW'(slot_q.row);
                    res_cnt_next = slot_q.dup + CW'(1);
                end
                else if (top_reg != '0 && ctop_reg.key == key_reg)
                begin
                    // The top spill entry is mirrored in ctop_reg; keep memory in step.
                    ctop_next.dup = ctop_reg.dup + CW'(1);
                    spill_we      = 1'b1;
                    spill_wa      = AW'(top_reg - CW'(1));
                    spill_wd.dup  = ctop_reg.dup + CW'(1);
                    rows_next     = rows_reg + CW'(1);
                    res_row_next  = CW'(ctop_reg.row);
                    res_cnt_next  = ctop_reg.dup + CW'(1);
                end
                else if (top_reg >= NO_LINK)
                begin
                    res_status_next = hibf_pkg::ST_OVERFLOW;
                end
                else
                begin
                    ctop_next.row  = AW'(rows_reg);
                    ctop_next.key  = key_reg;
                    ctop_next.home = home_reg;
                    ctop_next.dup  = CW'(1);
                    spill_we       = 1'b1;
                    spill_wa       = AW'(top_reg);
                    spill_wd       = ctop_next;
                    top_next       = top_reg + CW'(1);
                    rows_next      = rows_reg + CW'(1);
                    res_row_next   = rows_reg;
                    res_cnt_next   = CW'(1);
                end
            end

            S_FRD:
            begin
                if (scan_reg >= lim || top_reg == '0)
                begin
                    res_status_next = (top_reg != '0) ? hibf_pkg::ST_OVERFLOW
                                                      : hibf_pkg::ST_OK;
                    res_conf_next   = total_reg;
                    top_next        = '0;
                    ready_next      = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    slot_re    = 1'b1;
                    slot_ra    = AW'(scan_reg);
                    spill_re   = 1'b1;
                    spill_ra   = AW'(top_reg - CW'(1));
                    state_next = S_FCHK;
                end
            end

            S_FCHK:
            begin
                if (slot_q.used)
                begin
                    scan_next  = scan_reg + CW'(1);
                    state_next = S_FRD;
                end
                else
                begin
                    // Place the popped entry, then walk its home chain to the tail.
                    slot_we      = 1'b1;
                    slot_wa      = AW'(scan_reg);
                    slot_wd.used = 1'b1;
                    slot_wd.nxt  = NO_LINK;
                    slot_wd.dup  = spill_q.dup;
                    slot_wd.row  = spill_q.row;
                    slot_wd.key  = spill_q.key;
                    slot_re      = 1'b1;
                    slot_ra      = spill_q.home;
                    cur_next     = spill_q.home;
                    state_next   = S_FWALK;
                end
            end

            S_FWALK:
            begin
                if (slot_q.nxt != NO_LINK)
                begin
                    slot_re  = 1'b1;
                    slot_ra  = AW'(slot_q.nxt);
                    cur_next = AW'(slot_q.nxt);
                end
                else
                begin
                    slot_we     = 1'b1;
                    slot_wa     = cur_reg;
                    slot_wd.nxt = scan_reg;
                    top_next    = top_reg - CW'(1);
                    scan_next   = scan_reg + CW'(1);
                    state_next  = S_FRD;
                end
            end

            S_LK:
            begin
                if (!slot_q.used)
                begin
                    res_status_next = hibf_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else if (slot_q.key == key_reg)
                begin
                    res_row_next = CW'(slot_q.row);
                    res_cnt_next = slot_q.dup;
                    state_next   = S_DONE;
                end
                else if (slot_q.nxt == NO_LINK)
                begin
                    res_status_next = hibf_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    slot_re  = 1'b1;
                    slot_ra  = AW'(slot_q.nxt);
                    cur_next = AW'(slot_q.nxt);
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_row_next    = ROW_W'(res_row_reg);
                    out_cnt_next    = COUNT_W'(res_cnt_reg);
                    out_conf_next   = COUNT_W'(res_conf_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            clr_rsp_reg   <= 1'b0;
            top_reg       <= '0;
            rows_reg      <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            slots_reg     <= hibf_pkg::SLOTS_IN_USE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            clr_rsp_reg   <= clr_rsp_next;
            top_reg       <= top_next;
            rows_reg      <= rows_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                slots_reg <= cfg.slots_in_use;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        home_reg       <= home_next;
        key_reg        <= key_next;
        cur_reg        <= cur_next;
        scan_reg       <= scan_next;
        total_reg      <= total_next;
        ctop_reg       <= ctop_next;
        res_status_reg <= res_status_next;
        res_row_reg    <= res_row_next;
        res_cnt_reg    <= res_cnt_next;
        res_conf_reg   <= res_conf_next;
        out_status_reg <= out_status_next;
        out_row_reg    <= out_row_next;
        out_cnt_reg    <= out_cnt_next;
        out_conf_reg   <= out_conf_next;
    end

    // Every spill entry used up one row number.
    a_rows_cover_spill: assert property (@(posedge clk) disable iff (!rst_n)
        rows_reg >= top_reg)
        else $error("spill stack deeper than rows loaded");

    // Once the index is finalized the spill stack is empty.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (top_reg == '0))
        else $error("spill entries left after finalize");

    // The slot memory is only written while an operation is in progress.
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !slot_we)
        else $error("slot write outside an operation");

    // A result is moved to the output only when the output register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready && state_reg == S_DONE) |=> $stable(rsp.status))
        else $error("pending result overwritten");

endmodule
